// ===== rtl/core/two_unique_xor_finder_defines.svh =====
// assertion helpers shared by the rtl files
`ifndef TWO_UNIQUE_XOR_FINDER_DEFINES_SVH
`define TWO_UNIQUE_XOR_FINDER_DEFINES_SVH

// same-cycle implication, masked while reset is low
`define TUXF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is low
`define TUXF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tuxf_pkg.sv =====
`timescale 1ns / 1ps
package tuxf_pkg;

    // default element width
    localparam int DATA_WIDTH_DEF  = 32;
    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // round a bit count up to whole bytes
    function automatic int byte_round(input int bits);
        byte_round = ((bits + 7) / 8) * 8;
    endfunction

endpackage

// ===== rtl/core/tuxf_front.sv =====
`timescale 1ns / 1ps
`include "two_unique_xor_finder_defines.svh"
module tuxf_front
    import tuxf_pkg::*;
#(
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] in_value,
    input  logic                  in_last,
    output logic                  q_valid,
    input  logic                  q_ready,
    output logic [DATA_WIDTH-1:0] q_value,
    output logic                  q_last
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [DATA_WIDTH-1:0] value_mem [QUEUE_DEPTH];
    logic                  last_mem  [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready = (count_reg != CNT_FULL);
    assign q_valid  = (count_reg != '0);
    assign q_value  = value_mem[rd_ptr_reg];
    assign q_last   = last_mem[rd_ptr_reg];

    assign push = in_valid && in_ready;
    assign pop  = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage, payload only
    always_ff @(posedge aclk) begin
        if (push) begin
            value_mem[wr_ptr_reg] <= in_value;
            last_mem[wr_ptr_reg]  <= in_last;
        end
    end

    `TUXF_ASSERT_NEXT(a_fill_grows, aclk, aresetn, push && !pop,
        count_reg == $past(count_reg) + 1'b1, "queue count did not grow on push")
    `TUXF_ASSERT_NEXT(a_drain_shrinks, aclk, aresetn, pop && !push,
        count_reg == $past(count_reg) - 1'b1, "queue count did not shrink on pop")
    `TUXF_ASSERT_NEXT(a_both_steady, aclk, aresetn, push && pop,
        $stable(count_reg) && (wr_ptr_reg != $past(wr_ptr_reg) || QUEUE_DEPTH == 1),
        "queue count moved on push and pop")

endmodule

// ===== rtl/core/tuxf_back.sv =====
`timescale 1ns / 1ps
`include "two_unique_xor_finder_defines.svh"
module tuxf_back
    import tuxf_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  logic [DATA_WIDTH-1:0] q_value,
    input  logic                  q_last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] out_first,
    output logic [DATA_WIDTH-1:0] out_second,
    output logic                  out_no_pair
);

    logic [DATA_WIDTH-1:0] total_reg, total_next;
    logic [DATA_WIDTH-1:0] acc_reg  [DATA_WIDTH];
    logic [DATA_WIDTH-1:0] acc_next [DATA_WIDTH];
    logic [DATA_WIDTH-1:0] acc_upd  [DATA_WIDTH];
    logic [DATA_WIDTH-1:0] total_upd, lsb_hot, first_sel;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] first_reg, first_next;
    logic [DATA_WIDTH-1:0] second_reg, second_next;
    logic                  no_pair_reg, no_pair_next;
    logic                  take, out_free;

    // only a last item needs the output register
    assign out_free = !out_valid_reg || out_ready;
    assign q_ready  = !q_last || out_free;
    assign take     = q_valid && q_ready;

    always_comb begin
        total_upd = total_reg ^ q_value;
        for (int b = 0; b < DATA_WIDTH; b++) begin
            acc_upd[b] = q_value[b] ? (acc_reg[b] ^ q_value) : acc_reg[b];
        end
        // isolate lowest set bit of the final total
        lsb_hot   = total_upd & (~total_upd + 1'b1);
        first_sel = '0;
        for (int b = 0; b < DATA_WIDTH; b++) begin
            first_sel = first_sel | (acc_upd[b] & {DATA_WIDTH{lsb_hot[b]}});
        end
    end

    always_comb begin
        total_next     = total_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        first_next     = first_reg;
        second_next    = second_reg;
        no_pair_next   = no_pair_reg;
        if (take) begin
            if (q_last) begin
                total_next = '0;
                for (int b = 0; b < DATA_WIDTH; b++) begin
                    acc_next[b] = '0;
                end
                out_valid_next = 1'b1;
                first_next     = first_sel;
                second_next    = total_upd ^ first_sel;
                no_pair_next   = (total_upd == '0);
            end else begin
                total_next = total_upd;
                acc_next   = acc_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg     <= '0;
            for (int b = 0; b < DATA_WIDTH; b++) begin
                acc_reg[b] <= '0;
            end
            out_valid_reg <= 1'b0;
        end else begin
            total_reg     <= total_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_reg   <= first_next;
        second_reg  <= second_next;
        no_pair_reg <= no_pair_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_first   = first_reg;
    assign out_second  = second_reg;
    assign out_no_pair = no_pair_reg;

    `TUXF_ASSERT_NEXT(a_last_clears, aclk, aresetn, take && q_last,
        out_valid_reg && total_reg == '0, "last item did not post result and clear")
    `TUXF_ASSERT_NEXT(a_result_holds, aclk, aresetn, out_valid_reg && !out_ready,
        out_valid_reg && $stable(first_reg) && $stable(second_reg),
        "stalled result changed")
    `TUXF_ASSERT_NOW(a_no_pair_zero, aclk, aresetn, out_valid_reg && no_pair_reg,
        first_reg == '0 && second_reg == '0, "no pair result not zero")
    `TUXF_ASSERT_NOW(a_pair_differs, aclk, aresetn, out_valid_reg && !no_pair_reg,
        first_reg != second_reg, "uniques equal with nonzero total")

endmodule

// ===== rtl/core/two_unique_xor_finder.sv =====
`timescale 1ns / 1ps
// an accepted item is written into the front queue and then taken by the back end; its result
// (last item only) is registered in the result register that drives m_tvalid
// throughput: one item per cycle via accumulator update; a last item may wait on m_tready
// reset: aresetn low at a rising edge clears the queue, the running xor, all bit
// accumulators and the result valid flag
module two_unique_xor_finder
    import tuxf_pkg::*;
#(
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // value
    input  logic [byte_round(DATA_WIDTH)-1:0]          s_tdata,
    input  logic                                       s_tlast,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // first_unique, second_unique
    output logic [byte_round(2*DATA_WIDTH)-1:0]        m_tdata,
    // no_pair
    output logic                                       m_tuser
);

    localparam int M_TDATA_W = byte_round(2 * DATA_WIDTH);

    // queue between front and back
    logic                  q_valid, q_ready, q_last;
    logic [DATA_WIDTH-1:0] q_value;

    // result register outputs
    logic [DATA_WIDTH-1:0] first_unique, second_unique;
    logic                  no_pair;

    // front: takes items and parks them until the back end is free
    tuxf_front #(
        .DATA_WIDTH  (DATA_WIDTH),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_value (s_tdata[DATA_WIDTH-1:0]),
        .in_last  (s_tlast),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_value  (q_value),
        .q_last   (q_last)
    );

    // back: running xor, per-bit accumulators, result register
    // non-last items never stall here; a last item waits only for a free result slot
    tuxf_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_value     (q_value),
        .q_last      (q_last),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_first   (first_unique),
        .out_second  (second_unique),
        .out_no_pair (no_pair)
    );

    // pack results, first field lowest, zero padded to bytes
    assign m_tdata = M_TDATA_W'({second_unique, first_unique});
    assign m_tuser = no_pair;

endmodule
